>>> hdl/hotp_pkg.sv
`default_nettype none
package hotp_pkg;

    localparam int KeyWords    = 7;
    localparam int KeyMaxBytes = 56;
    localparam int RegIdxW     = 3;
    localparam int RegKeyLen   = 7;
    localparam logic [19:0] OtpModulus = 20'd1000000;
    // ceil(2^51 / 1000000), exact quotient for any 31-bit dividend
    localparam logic [31:0] OtpRecip   = 32'd2251799814;

    localparam logic [31:0] H0 = 32'h67452301;
    localparam logic [31:0] H1 = 32'hEFCDAB89;
    localparam logic [31:0] H2 = 32'h98BADCFE;
    localparam logic [31:0] H3 = 32'h10325476;
    localparam logic [31:0] H4 = 32'hC3D2E1F0;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOAD,
        ST_ROUND,
        ST_ADD,
        ST_TRUNC,
        ST_MOD,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic [31:0] a;
        logic [31:0] b;
        logic [31:0] c;
        logic [31:0] d;
        logic [31:0] e;
    } sha_state_t;

    function automatic logic [31:0] round_k(input logic [6:0] r);
        logic [31:0] k;
        begin
            if (r < 7'd20)
            begin
                k = 32'h5A827999;
            end
            else if (r < 7'd40)
            begin
                k = 32'h6ED9EBA1;
            end
            else if (r < 7'd60)
            begin
                k = 32'h8F1BBCDC;
            end
            else
            begin
                k = 32'hCA62C1D6;
            end
            return k;
        end
    endfunction

    function automatic logic [31:0] round_f(input logic [6:0] r, input logic [31:0] b,
                                            input logic [31:0] c, input logic [31:0] d);
        logic [31:0] f;
        begin
            if (r < 7'd20)
            begin
                f = (b & c) | (~b & d);
            end
            else if (r >= 7'd40 && r < 7'd60)
            begin
                f = (b & c) | (b & d) | (c & d);
            end
            else
            begin
                f = b ^ c ^ d;
            end
            return f;
        end
    endfunction

endpackage
`default_nettype wire

>>> hdl/hotp_if.sv
`default_nettype none
interface hotp_in_if;
    logic        valid;
    logic        ready;
    logic [63:0] moving_counter;
    modport source (output valid, output moving_counter, input ready);
    modport sink (input valid, input moving_counter, output ready);
endinterface

interface hotp_out_if;
    logic        valid;
    logic        ready;
    logic [19:0] password;
    modport source (output valid, output password, input ready);
    modport sink (input valid, input password, output ready);
endinterface

interface hotp_cfg_if;
    logic        valid;
    logic        ready;
    logic [2:0]  index;
    logic [63:0] data;
    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

>>> hdl/hotp_hmac_sha1_generator.sv
// four sha-1 compressions on one shared round unit, each a load state, 80 rounds
// and an add state, then a truncation state and a reciprocal reduction modulo 1000000
// in the mod state, quotient first and then remainder
// one counter at a time: a new counter is taken only in idle, so the
// input is not ready until the password transaction completes
// reset: asynchronous active low, idle with key registers and key length cleared to zero
`default_nettype none
module hotp_hmac_sha1_generator (
    input  wire logic   clk,
    input  wire logic   rst_n,
    hotp_cfg_if.sink    cfg,
    hotp_in_if.sink     in_ch,
    hotp_out_if.source  out_ch
);

    logic [63:0]          key_reg [hotp_pkg::KeyWords];
    logic [5:0]           key_len_reg;
    hotp_pkg::state_t     state_reg, state_next;
    logic [63:0]          ctr_reg;
    logic [31:0]          w_reg [16];
    hotp_pkg::sha_state_t v_reg;
    logic [159:0]         h_reg;
    logic [159:0]         inner_reg;
    logic [6:0]           rnd_reg;
    logic [1:0]           blk_reg;
    logic                 mstep_reg;
    logic [30:0]          code_reg;
    logic [11:0]          q_reg;
    logic [19:0]          pwd_reg;

    logic [5:0]   klen;
    logic [511:0] padkey;
    logic [511:0] blk;
    logic [31:0]  wt, wnew, tsum;
    logic [159:0] hsum;
    logic [3:0]   off;
    logic [62:0]  prod;
    logic [19:0]  rem;

    assign cfg.ready    = 1'b1;
    assign in_ch.ready  = (state_reg == hotp_pkg::ST_IDLE);
    assign out_ch.valid = (state_reg == hotp_pkg::ST_DONE);
    assign out_ch.password = pwd_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < hotp_pkg::KeyWords; i++)
            begin
                key_reg[i] <= '0;
            end
            key_len_reg <= '0;
        end
        else if (cfg.valid)
        begin
            if (cfg.index == 3'(hotp_pkg::RegKeyLen))
            begin
                key_len_reg <= cfg.data[5:0];
            end
            else
            begin
                key_reg[cfg.index] <= cfg.data;
            end
        end
    end

    always_comb
    begin
        klen = (key_len_reg > 6'(hotp_pkg::KeyMaxBytes)) ? 6'(hotp_pkg::KeyMaxBytes)
                                                        : key_len_reg;
        padkey = '0;
        for (int i = 0; i < hotp_pkg::KeyMaxBytes; i++)
        begin
            if (6'(i) < klen)
            begin
                padkey[511 - 8*i -: 8] = key_reg[i/8][63 - 8*(i%8) -: 8];
            end
        end
    end

    // message block selection: inner key, inner tail, outer key, outer tail
    always_comb
    begin
        unique case (blk_reg)
            2'd0: blk = padkey ^ {64{8'h36}};
            2'd1: blk = {ctr_reg, 8'h80, 376'd0, 64'd576};
            2'd2: blk = padkey ^ {64{8'h5c}};
            default: blk = {inner_reg, 8'h80, 280'd0, 64'd672};
        endcase
    end

    assign wt   = w_reg[0];
    assign wnew = {w_reg[13] ^ w_reg[8] ^ w_reg[2] ^ w_reg[0]} << 1
                | {w_reg[13] ^ w_reg[8] ^ w_reg[2] ^ w_reg[0]} >> 31;
    assign tsum = {v_reg.a[26:0], v_reg.a[31:27]}
                + hotp_pkg::round_f(rnd_reg, v_reg.b, v_reg.c, v_reg.d)
                + v_reg.e + hotp_pkg::round_k(rnd_reg) + wt;
    assign hsum = {h_reg[159:128] + v_reg.a, h_reg[127:96] + v_reg.b,
                   h_reg[95:64] + v_reg.c, h_reg[63:32] + v_reg.d, h_reg[31:0] + v_reg.e};
    assign off   = h_reg[3:0];
    // quotient by reciprocal multiplication, remainder only needs the low 20 bits
    assign prod  = {32'd0, code_reg} * {31'd0, hotp_pkg::OtpRecip};
    assign rem   = code_reg[19:0] - ({8'd0, q_reg} * hotp_pkg::OtpModulus);

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            hotp_pkg::ST_IDLE:  if (in_ch.valid) state_next = hotp_pkg::ST_LOAD;
            hotp_pkg::ST_LOAD:  state_next = hotp_pkg::ST_ROUND;
            hotp_pkg::ST_ROUND: if (rnd_reg == 7'd79) state_next = hotp_pkg::ST_ADD;
            hotp_pkg::ST_ADD:   state_next = (blk_reg == 2'd3) ? hotp_pkg::ST_TRUNC
                                                               : hotp_pkg::ST_LOAD;
            hotp_pkg::ST_TRUNC: state_next = hotp_pkg::ST_MOD;
            hotp_pkg::ST_MOD:   if (mstep_reg) state_next = hotp_pkg::ST_DONE;
            hotp_pkg::ST_DONE:  if (out_ch.ready) state_next = hotp_pkg::ST_IDLE;
            default:            state_next = hotp_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= hotp_pkg::ST_IDLE;
            blk_reg   <= '0;
            rnd_reg   <= '0;
            mstep_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            unique case (state_reg)
                hotp_pkg::ST_IDLE:
                begin
                    blk_reg <= '0;
                end
                hotp_pkg::ST_LOAD:
                begin
                    rnd_reg <= '0;
                end
                hotp_pkg::ST_ROUND:
                begin
                    rnd_reg <= rnd_reg + 7'd1;
                end
                hotp_pkg::ST_ADD:
                begin
                    blk_reg <= blk_reg + 2'd1;
                end
                hotp_pkg::ST_TRUNC:
                begin
                    mstep_reg <= '0;
                end
                hotp_pkg::ST_MOD:
                begin
                    mstep_reg <= mstep_reg + 1'b1;
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            hotp_pkg::ST_IDLE:
            begin
                ctr_reg <= in_ch.moving_counter;
                h_reg   <= {hotp_pkg::H0, hotp_pkg::H1, hotp_pkg::H2,
                            hotp_pkg::H3, hotp_pkg::H4};
            end
            hotp_pkg::ST_LOAD:
            begin
                for (int i = 0; i < 16; i++)
                begin
                    w_reg[i] <= blk[511 - 32*i -: 32];
                end
                v_reg <= h_reg;
            end
            hotp_pkg::ST_ROUND:
            begin
                for (int i = 0; i < 15; i++)
                begin
                    w_reg[i] <= w_reg[i+1];
                end
                w_reg[15] <= wnew;
                v_reg <= '{a: tsum, b: v_reg.a, c: {v_reg.b[1:0], v_reg.b[31:2]},
                           d: v_reg.c, e: v_reg.d};
            end
            hotp_pkg::ST_ADD:
            begin
                if (blk_reg == 2'd1)
                begin
                    // inner hash done, outer hash starts from the initial values
                    inner_reg <= hsum;
                    h_reg     <= {hotp_pkg::H0, hotp_pkg::H1, hotp_pkg::H2,
                                  hotp_pkg::H3, hotp_pkg::H4};
                end
                else
                begin
                    h_reg <= hsum;
                end
            end
            hotp_pkg::ST_TRUNC:
            begin
                code_reg <= h_reg[159 - 8*off - 1 -: 31];
            end
            hotp_pkg::ST_MOD:
            begin
                if (!mstep_reg)
                begin
                    q_reg <= prod[62:51];
                end
                else
                begin
                    pwd_reg <= rem;
                end
            end
            default:
            begin
            end
        endcase
    end

`ifndef NO_ASSERTIONS
    a_round_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == hotp_pkg::ST_ROUND) |-> (rnd_reg <= 7'd79))
        else $error("round counter overrun");
    a_pwd_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_ch.valid |-> (pwd_reg < hotp_pkg::OtpModulus))
        else $error("password out of range");
    a_quot_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == hotp_pkg::ST_MOD && mstep_reg) |-> (q_reg <= 12'd2147))
        else $error("quotient out of range");
`endif

endmodule
`default_nettype wire

>>> tb/tb.sv
`default_nettype none
module tb;

    typedef enum int {
        PH_NONE,
        PH_SRC_IDLE,
        PH_SNK_STALL,
        PH_BOTH
    } idle_phase_t;

    logic clk;
    logic rst_n;

    hotp_cfg_if cfg ();
    hotp_in_if in_ch ();
    hotp_out_if out_ch ();

    hotp_hmac_sha1_generator dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .cfg    (cfg.sink),
        .in_ch  (in_ch.sink),
        .out_ch (out_ch.source)
    );

    // key and length as the block should hold them
    logic [63:0] key_words [hotp_pkg::KeyWords];
    logic [5:0]  key_len;

    logic [63:0] counter_q [$];
    logic [19:0] password_q [$];
    int          errors;
    int          n_sent;
    int          n_checked;
    int          hold_cycles;
    idle_phase_t phase;
    logic        in_fire;

    always
    begin
        clk = 1'b1;
        #10;
        clk = 1'b0;
        #10;
    end

    function automatic logic [31:0] rotl(input logic [31:0] x, input int n);
        return (x << n) | (x >> (32 - n));
    endfunction

    // one compression on a 512-bit block, big-endian words
    function automatic void compress(inout logic [31:0] h [5], input logic [511:0] blk);
        logic [31:0] w [80];
        logic [31:0] a, b, c, d, e, f, k, t;
        for (int i = 0; i < 16; i++)
        begin
            w[i] = blk[511 - 32 * i -: 32];
        end
        for (int i = 16; i < 80; i++)
        begin
            w[i] = rotl(w[i - 3] ^ w[i - 8] ^ w[i - 14] ^ w[i - 16], 1);
        end
        a = h[0];
        b = h[1];
        c = h[2];
        d = h[3];
        e = h[4];
        for (int i = 0; i < 80; i++)
        begin
            if (i < 20)
            begin
                f = (b & c) | (~b & d);
                k = 32'h5A827999;
            end
            else if (i < 40)
            begin
                f = b ^ c ^ d;
                k = 32'h6ED9EBA1;
            end
            else if (i < 60)
            begin
                f = (b & c) | (b & d) | (c & d);
                k = 32'h8F1BBCDC;
            end
            else
            begin
                f = b ^ c ^ d;
                k = 32'hCA62C1D6;
            end
            t = rotl(a, 5) + f + e + k + w[i];
            e = d;
            d = c;
            c = rotl(b, 30);
            b = a;
            a = t;
        end
        h[0] += a;
        h[1] += b;
        h[2] += c;
        h[3] += d;
        h[4] += e;
    endfunction

    // hash of 64 key-derived bytes followed by a tail of tail_bytes bytes (<= 55)
    function automatic logic [159:0] hash_pad_block(input logic [511:0] first,
                                                    input logic [439:0] tail,
                                                    input int tail_bytes);
        logic [31:0]  h [5];
        logic [511:0] second;
        h[0] = 32'h67452301;
        h[1] = 32'hEFCDAB89;
        h[2] = 32'h98BADCFE;
        h[3] = 32'h10325476;
        h[4] = 32'hC3D2E1F0;
        compress(h, first);
        second = '0;
        for (int i = 0; i < tail_bytes; i++)
        begin
            second[511 - 8 * i -: 8] = tail[439 - 8 * i -: 8];
        end
        second[511 - 8 * tail_bytes -: 8] = 8'h80;
        second[63:0] = 64'(64 + tail_bytes) * 8;
        compress(h, second);
        return {h[0], h[1], h[2], h[3], h[4]};
    endfunction

    function automatic logic [19:0] hotp_password(input logic [63:0] ctr);
        logic [511:0] padded;
        logic [159:0] inner_mac, mac;
        logic [439:0] tail;
        logic [7:0]   mb [20];
        logic [31:0]  code;
        int           len;
        int           off;
        len = (key_len > 6'(hotp_pkg::KeyMaxBytes)) ? hotp_pkg::KeyMaxBytes : int'(key_len);
        padded = '0;
        for (int i = 0; i < len; i++)
        begin
            padded[511 - 8 * i -: 8] = key_words[i / 8][63 - 8 * (i % 8) -: 8];
        end
        tail = '0;
        tail[439 -: 64] = ctr;
        inner_mac = hash_pad_block(padded ^ {64{8'h36}}, tail, 8);
        tail = '0;
        tail[439 -: 160] = inner_mac;
        mac = hash_pad_block(padded ^ {64{8'h5c}}, tail, 20);
        for (int i = 0; i < 20; i++)
        begin
            mb[i] = mac[159 - 8 * i -: 8];
        end
        off = mb[19] & 8'h0f;
        code = {mb[off] & 8'h7f, mb[off + 1], mb[off + 2], mb[off + 3]};
        return 20'(code % 32'd1000000);
    endfunction

    task automatic write_reg(input logic [2:0] idx, input logic [63:0] value);
        @(negedge clk);
        cfg.valid <= 1'b1;
        cfg.index <= idx;
        cfg.data  <= value;
        @(posedge clk);
        while (!cfg.ready)
        begin
            @(posedge clk);
        end
        @(negedge clk);
        cfg.valid <= 1'b0;
        if (idx < 3'(hotp_pkg::KeyWords))
        begin
            key_words[idx] = value;
        end
        else if (idx == 3'(hotp_pkg::RegKeyLen))
        begin
            key_len = value[5:0];
        end
    endtask

    task automatic load_key(input logic [5:0] len);
        for (int i = 0; i < hotp_pkg::KeyWords; i++)
        begin
            write_reg(3'(i), {$urandom, $urandom});
        end
        write_reg(3'(hotp_pkg::RegKeyLen), {$urandom, 26'($urandom), len});
    endtask

    // wait for all passwords, then the block's tail latency before touching keys
    task automatic drain();
        int guard;
        guard = 0;
        while ((counter_q.size() != 0 || password_q.size() != 0) && guard < 2000000)
        begin
            @(posedge clk);
            guard++;
        end
        repeat (400) @(posedge clk);
    endtask

    task automatic run_counters(input int n, input idle_phase_t ph);
        phase = ph;
        for (int i = 0; i < n; i++)
        begin
            case ($urandom_range(0, 5))
                0: counter_q.push_back(64'h0);
                1: counter_q.push_back('1);
                2: counter_q.push_back(64'(n_sent + i));
                default: counter_q.push_back({$urandom, $urandom});
            endcase
        end
        drain();
    endtask

    // input transaction seen at the rising edge, used by the driver at the next falling edge
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            in_fire <= 1'b0;
        end
        else
        begin
            in_fire <= in_ch.valid && in_ch.ready;
        end
    end

    // driver
    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            in_ch.valid <= 1'b0;
        end
        else
        begin
            if (in_fire)
            begin
                n_sent++;
            end
            if (!in_ch.valid || in_fire)
            begin
                if (counter_q.size() != 0 &&
                    !((phase == PH_SRC_IDLE && $urandom_range(0, 99) < 45) ||
                      (phase == PH_BOTH && $urandom_range(0, 99) < 10)))
                begin
                    in_ch.valid          <= 1'b1;
                    in_ch.moving_counter <= counter_q[0];
                    password_q.push_back(hotp_password(counter_q.pop_front()));
                end
                else
                begin
                    in_ch.valid <= 1'b0;
                end
            end
        end
    end

    always @(negedge clk)
    begin
        if (hold_cycles > 0)
        begin
            out_ch.ready <= 1'b0;
            hold_cycles--;
        end
        else if (phase == PH_SNK_STALL)
        begin
            out_ch.ready <= ($urandom_range(0, 99) >= 45);
        end
        else if (phase == PH_BOTH)
        begin
            out_ch.ready <= ($urandom_range(0, 99) >= 10);
        end
        else
        begin
            out_ch.ready <= 1'b1;
        end
    end

    // monitor
    always @(posedge clk)
    begin
        if (rst_n && out_ch.valid && out_ch.ready)
        begin
            if (password_q.size() == 0)
            begin
                $display("%0t: unexpected password, expected none, got %0d",
                         $time, out_ch.password);
                errors++;
            end
            else
            begin
                if (out_ch.password !== password_q[0])
                begin
                    $display("%0t: password mismatch, expected %0d, got %0d",
                             $time, password_q[0], out_ch.password);
                    errors++;
                end
                void'(password_q.pop_front());
                n_checked++;
            end
        end
    end

    initial
    begin
        #400000000;
        $display("tb NOT OK");
        $finish;
    end

    initial
    begin
        rst_n = 1'b0;
        errors = 0;
        n_sent = 0;
        n_checked = 0;
        hold_cycles = 0;
        phase = PH_NONE;
        cfg.valid = 1'b0;
        cfg.index = '0;
        cfg.data = '0;
        in_ch.valid = 1'b0;
        in_ch.moving_counter = '0;
        out_ch.ready = 1'b0;
        for (int i = 0; i < hotp_pkg::KeyWords; i++)
        begin
            key_words[i] = '0;
        end
        key_len = '0;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed: reset key (empty), counter extremes and single-bit patterns
        counter_q.push_back(64'h0);
        counter_q.push_back('1);
        counter_q.push_back(64'h8000_0000_0000_0000);
        counter_q.push_back(64'h1);
        drain();
        // rfc test key "12345678901234567890", counters 0..9
        write_reg(3'd0, 64'h3132333435363738);
        write_reg(3'd1, 64'h3930313233343536);
        write_reg(3'd2, 64'h3738393000000000);
        write_reg(3'(hotp_pkg::RegKeyLen), 64'd20);
        for (int i = 0; i < 10; i++)
        begin
            counter_q.push_back(64'(i));
        end
        drain();
        // full key, oversized length (saturates), unused bytes, bad lengths
        load_key(6'd56);
        counter_q.push_back(64'h0123_4567_89ab_cdef);
        counter_q.push_back('1);
        drain();
        load_key(6'd63);
        counter_q.push_back(64'h0123_4567_89ab_cdef);
        drain();
        load_key(6'd1);
        counter_q.push_back(64'h5555_aaaa_5555_aaaa);
        counter_q.push_back(64'haaaa_5555_aaaa_5555);
        drain();
        load_key(6'd0);
        counter_q.push_back(64'hffff_0000_ffff_0000);
        drain();

        // random phases under a handful of keys
        load_key(6'($urandom_range(0, 56)));
        run_counters(200, PH_NONE);
        load_key(6'($urandom_range(57, 63)));
        run_counters(200, PH_SRC_IDLE);
        load_key(6'($urandom_range(1, 55)));
        // long receiver hold while counters keep coming
        hold_cycles = 3000;
        run_counters(200, PH_SNK_STALL);
        load_key(6'd56);
        run_counters(220, PH_BOTH);

        if (counter_q.size() != 0 || password_q.size() != 0)
        begin
            $display("%0t: passwords missing, expected %0d more, got none",
                     $time, counter_q.size() + password_q.size());
            errors++;
        end

        $display("covered %0d counters, %0d passwords checked, keys of 0 to 63 bytes",
                 n_sent, n_checked);
        if (errors == 0)
        begin
            $display("tb OK");
        end
        else
        begin
            $display("tb NOT OK");
        end
        $finish;
    end

endmodule
`default_nettype wire
